FILE: src/mpk_pkg.sv
// Shared constants, types and the cell control bundle for the k-trade profit block.
// No dependencies; used by mpk_cell and max_profit_k_trades_top.
package mpk_pkg;

   localparam int MAX_TRADES  = 64;
   localparam int TRADE_BITS  = $clog2(MAX_TRADES + 1);
   localparam int SLOT_BITS   = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;
   localparam int PRICE_BITS  = 16;
   localparam int PROFIT_BITS = 32;
   localparam int HOLD_BITS   = PROFIT_BITS + 2;
   localparam int CFG_BITS    = 7;
   localparam int LIMIT_RESET = 2;

   localparam logic [PROFIT_BITS-1:0] PROFIT_MAX = '1;
   localparam logic signed [HOLD_BITS-1:0] HOLD_MIN = {1'b1, {(HOLD_BITS-1){1'b0}}};

   // Per-beat control broadcast along the row of cells
   typedef struct packed {
      logic                  en;
      logic                  clr;
      logic [PRICE_BITS-1:0] price;
   } cell_ctl_type;

   // Source of the reported profit
   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_RISE,
      SEL_SLOT
   } sel_type;

endpackage

FILE: src/mpk_cell.sv
// One trade slot: best value while holding and best value after its sale.
// Uses mpk_pkg; takes the previous slot's sold value from its left neighbor.
module mpk_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mpk_pkg::cell_ctl_type                  ctl,
   input  logic [mpk_pkg::PROFIT_BITS-1:0]        below_sold,
   output logic [mpk_pkg::PROFIT_BITS-1:0]        sold_out
);

   localparam int SUM_BITS = mpk_pkg::HOLD_BITS + 1;

   logic signed [mpk_pkg::HOLD_BITS-1:0] hold_ff, hold_in, hold_old;
   logic [mpk_pkg::PROFIT_BITS-1:0]      sold_ff, sold_in, sold_old, below;
   logic signed [SUM_BITS-1:0]           sell, buy, price_ext;

   // Treat the slot as freshly cleared when a new series starts
   always_comb begin
      hold_old  = ctl.clr ? mpk_pkg::HOLD_MIN : hold_ff;
      sold_old  = ctl.clr ? '0 : sold_ff;
      below     = ctl.clr ? '0 : below_sold;
      price_ext = $signed({{(SUM_BITS-mpk_pkg::PRICE_BITS){1'b0}}, ctl.price});
      sell      = $signed({hold_old[mpk_pkg::HOLD_BITS-1], hold_old}) + price_ext;
      buy       = $signed({{(SUM_BITS-mpk_pkg::PROFIT_BITS){1'b0}}, below}) - price_ext;
   end

   // Sell from holding, saturating the profit
   always_comb begin
      sold_in = sold_old;
      if (sell > $signed({{(SUM_BITS-mpk_pkg::PROFIT_BITS){1'b0}}, sold_old})) begin
         if (sell > $signed({{(SUM_BITS-mpk_pkg::PROFIT_BITS){1'b0}}, mpk_pkg::PROFIT_MAX}))
            sold_in = mpk_pkg::PROFIT_MAX;
         else
            sold_in = sell[mpk_pkg::PROFIT_BITS-1:0];
      end
   end

   // Buy on top of the previous slot's sale
   always_comb begin
      hold_in = hold_old;
      if (buy > $signed({hold_old[mpk_pkg::HOLD_BITS-1], hold_old}))
         hold_in = buy[mpk_pkg::HOLD_BITS-1:0];
   end

   // Advance the slot on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= mpk_pkg::HOLD_MIN;
         sold_ff <= '0;
      end else if (ctl.en) begin
         hold_ff <= hold_in;
         sold_ff <= sold_in;
      end
   end

   assign sold_out = sold_ff;

endmodule

FILE: src/max_profit_k_trades_top.sv
// Top level of the k-trade profit block: series tracking, cell row, result stage.
// Uses mpk_pkg and instantiates one mpk_cell per trade slot.
//
// Takes one price beat per cycle while the result side is not stalled, and returns
// one profit beat for each through the select stage and the output register. All
// MAX_TRADES cells of the row update in the cycle a price is taken; the select stage
// then moves the slot named by trade_limit (or the running rise sum) into the output
// register. A stalled result register lets one more beat into the select stage and
// then holds the input off until the result is taken. csr_ready is always high;
// write trade_limit only while no beat is in flight.
module max_profit_k_trades_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mpk_pkg::PRICE_BITS-1:0]     req_price,
   input  logic                               req_first,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mpk_pkg::PROFIT_BITS-1:0]    rsp_profit,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mpk_pkg::CFG_BITS-1:0]       csr_trade_limit
);

   localparam int PB = mpk_pkg::PROFIT_BITS;

   logic [mpk_pkg::TRADE_BITS-1:0] trade_limit_ff;
   logic [mpk_pkg::SLOT_BITS-1:0]  slot;
   logic [PB-1:0]                  item_count_ff, item_count_in, count_old;
   logic [PB-1:0]                  rise_ff, rise_in, rise_old;
   logic [mpk_pkg::PRICE_BITS-1:0] last_ff, last_old;
   logic [PB:0]                    rise_sum;
   logic                           s1_valid_ff, s1_advance, req_accept;
   mpk_pkg::sel_type               s1_sel_ff, sel_in;
   logic                           rsp_valid_ff;
   logic [PB-1:0]                  rsp_profit_ff, profit_in;
   mpk_pkg::cell_ctl_type          ctl;
   logic [PB-1:0]                  sold_vec [mpk_pkg::MAX_TRADES];

   // Handshakes
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_profit = rsp_profit_ff;

   // Hold the clamped trade limit
   always_ff @(posedge clock) begin
      if (reset) begin
         trade_limit_ff <= mpk_pkg::TRADE_BITS'(mpk_pkg::LIMIT_RESET);
      end else if (csr_valid && csr_ready) begin
         if (int'(csr_trade_limit) > mpk_pkg::MAX_TRADES)
            trade_limit_ff <= mpk_pkg::TRADE_BITS'(mpk_pkg::MAX_TRADES);
         else
            trade_limit_ff <= mpk_pkg::TRADE_BITS'(csr_trade_limit);
      end
   end

   assign slot = mpk_pkg::SLOT_BITS'(trade_limit_ff - 1'b1);

   // Series tracking: count, last price, sum of rises
   always_comb begin
      count_old = req_first ? '0 : item_count_ff;
      rise_old  = req_first ? '0 : rise_ff;
      last_old  = req_first ? '0 : last_ff;
      rise_sum  = {1'b0, rise_old} + {{(PB+1-mpk_pkg::PRICE_BITS){1'b0}}, req_price}
                - {{(PB+1-mpk_pkg::PRICE_BITS){1'b0}}, last_old};
      rise_in   = rise_old;
      if (count_old != '0 && req_price > last_old)
         rise_in = rise_sum[PB] ? mpk_pkg::PROFIT_MAX : rise_sum[PB-1:0];
      item_count_in = (count_old == '1) ? count_old : count_old + 1'b1;
   end

   // Choose the result source for this beat
   always_comb begin
      if (item_count_in <= PB'(1))
         sel_in = mpk_pkg::SEL_ZERO;
      else if (PB'(trade_limit_ff) > (item_count_in >> 1))
         sel_in = mpk_pkg::SEL_RISE;
      else if (trade_limit_ff == '0)
         sel_in = mpk_pkg::SEL_ZERO;
      else
         sel_in = mpk_pkg::SEL_SLOT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         rise_ff       <= '0;
         last_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s1_sel_ff     <= mpk_pkg::SEL_ZERO;
      end else begin
         if (req_accept) begin
            item_count_ff <= item_count_in;
            rise_ff       <= rise_in;
            last_ff       <= req_price;
            s1_sel_ff     <= sel_in;
         end
         if (req_accept)
            s1_valid_ff <= 1'b1;
         else if (s1_advance)
            s1_valid_ff <= 1'b0;
      end
   end

   // Row of trade-slot cells
   always_comb begin
      ctl.en    = req_accept;
      ctl.clr   = req_first;
      ctl.price = req_price;
   end

   for (genvar k = 0; k < mpk_pkg::MAX_TRADES; k++) begin : g_cell
      logic [PB-1:0] below;
      if (k == 0) begin : g_edge
         assign below = '0;
      end else begin : g_link
         assign below = sold_vec[k-1];
      end
      mpk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .below_sold (below),
         .sold_out   (sold_vec[k])
      );
   end

   // Select the profit into the output register
   always_comb begin
      case (s1_sel_ff)
         mpk_pkg::SEL_RISE: profit_in = rise_ff;
         mpk_pkg::SEL_SLOT: profit_in = sold_vec[slot];
         default:           profit_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff)
         rsp_profit_ff <= profit_in;
   end

   // Checks
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted beat did not reach the select stage");

   a_first_restarts_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_first |=> item_count_ff == PB'(1))
      else $error("series start did not restart the item count");

   a_blocked_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(rise_ff)
         && $stable(s1_sel_ff))
      else $error("blocked select stage lost its beat");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for max_profit_k_trades_top: streams price series, predicts
// the k-trade profit of every beat and compares each result beat. Depends on mpk_pkg.
module testbench;

   localparam int ITEM_TARGET    = 1900;
   localparam int CALM_FROM      = 1700;
   localparam int PRESSURE_AT    = 600;
   localparam int HOLD_OFF_LEN   = 250;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_CAP      = 50;

   // Predicts the best profit per price and holds the profits still owed by the block
   class profit_scoreboard;
      logic signed [mpk_pkg::HOLD_BITS-1:0] hold_best [mpk_pkg::MAX_TRADES];
      logic [mpk_pkg::PROFIT_BITS-1:0]      sold_best [mpk_pkg::MAX_TRADES];
      logic [mpk_pkg::PROFIT_BITS-1:0]      rise_sum;
      logic [mpk_pkg::PRICE_BITS-1:0]       last_price;
      logic [31:0]                          price_count;
      logic [mpk_pkg::TRADE_BITS-1:0]       trade_limit;
      logic [mpk_pkg::PROFIT_BITS-1:0]      owed_profits [$];
      int                                   errors;
      int                                   checked;

      function new();
         errors = 0;
         checked = 0;
         trade_limit = mpk_pkg::TRADE_BITS'(mpk_pkg::LIMIT_RESET);
         clear_series();
      endfunction

      function void clear_series();
         for (int k = 0; k < mpk_pkg::MAX_TRADES; k++) begin
            hold_best[k] = mpk_pkg::HOLD_MIN;
            sold_best[k] = '0;
         end
         rise_sum = '0;
         last_price = '0;
         price_count = '0;
      endfunction

      function longint clamp_profit(longint v);
         if (v < 0) return 0;
         if (v > longint'(mpk_pkg::PROFIT_MAX)) return longint'(mpk_pkg::PROFIT_MAX);
         return v;
      endfunction

      // Clamp the write to the number of trade slots
      function void set_limit(logic [mpk_pkg::CFG_BITS-1:0] value);
         if (value > mpk_pkg::MAX_TRADES)
            trade_limit = mpk_pkg::TRADE_BITS'(mpk_pkg::MAX_TRADES);
         else trade_limit = mpk_pkg::TRADE_BITS'(value);
      endfunction

      function int pending();
         return owed_profits.size();
      endfunction

      // Advance every trade slot from the previous beat's values, then pick the profit
      function void note_price(logic [mpk_pkg::PRICE_BITS-1:0] price, logic first);
         logic [mpk_pkg::PROFIT_BITS-1:0] sold_prev [mpk_pkg::MAX_TRADES];
         longint pv, below, sell, buy, held, sold_k, rs, lp, profit;
         if (first) clear_series();
         pv = price;
         lp = last_price;
         rs = rise_sum;
         if (price_count != 0 && pv > lp)
            rise_sum = mpk_pkg::PROFIT_BITS'(clamp_profit(rs + pv - lp));
         sold_prev = sold_best;
         for (int k = 0; k < mpk_pkg::MAX_TRADES; k++) begin
            below = (k > 0) ? longint'(sold_prev[k-1]) : 0;
            held = hold_best[k];
            sold_k = sold_prev[k];
            sell = held + pv;
            buy = below - pv;
            if (sell > sold_k) sold_best[k] = mpk_pkg::PROFIT_BITS'(clamp_profit(sell));
            if (buy > held) hold_best[k] = mpk_pkg::HOLD_BITS'(buy);
         end
         last_price = price;
         if (price_count != 32'hFFFF_FFFF) price_count++;
         if (price_count <= 1) profit = 0;
         else if (trade_limit > price_count / 2) profit = rise_sum;
         else if (trade_limit == 0) profit = 0;
         else profit = sold_best[trade_limit-1];
         owed_profits.push_back(mpk_pkg::PROFIT_BITS'(clamp_profit(profit)));
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("mismatch: %s", what);
      endtask

      task check_profit(logic [mpk_pkg::PROFIT_BITS-1:0] got);
         logic [mpk_pkg::PROFIT_BITS-1:0] want;
         checked++;
         if (owed_profits.size() == 0) begin
            report($sformatf("result beat %0d profit %0d with nothing owed", checked, got));
         end else begin
            want = owed_profits.pop_front();
            if (got !== want)
               report($sformatf("result beat %0d profit %0d, predicted %0d",
                                checked, got, want));
         end
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [mpk_pkg::PRICE_BITS-1:0]  req_price = '0;
   logic                            req_first = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [mpk_pkg::PROFIT_BITS-1:0] rsp_profit;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [mpk_pkg::CFG_BITS-1:0]    csr_trade_limit = '0;

   profit_scoreboard sb;
   int  sent = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_off_req = 1'b0;

   max_profit_k_trades_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_price       (req_price),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_profit      (rsp_profit),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_trade_limit (csr_trade_limit)
   );

   always #5 clock = ~clock;

   // Track every beat that crosses a port
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_limit(csr_trade_limit);
         if (req_valid && !req_stall) sb.note_price(req_price, req_first);
         if (rsp_valid && !rsp_stall) sb.check_profit(rsp_profit);
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none when calm
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_LEN) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offer one price beat and hold it until taken
   task send_price(logic [mpk_pkg::PRICE_BITS-1:0] price, logic first);
      req_valid <= 1'b1;
      req_price <= price;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task pause(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Let every owed profit come back, then give the block a few more cycles
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_limit(logic [mpk_pkg::CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_trade_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [mpk_pkg::CFG_BITS-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return mpk_pkg::CFG_BITS'(mpk_pkg::MAX_TRADES);
         2: return mpk_pkg::CFG_BITS'($urandom_range(mpk_pkg::MAX_TRADES + 1, 127));
         3: return mpk_pkg::CFG_BITS'($urandom_range(0, 127));
         4: return mpk_pkg::CFG_BITS'(mpk_pkg::MAX_TRADES - 1);
         default: return mpk_pkg::CFG_BITS'($urandom_range(1, 8));
      endcase
   endfunction

   // Step the price by one of several shapes: uniform, walk, extremes, trend
   function automatic logic [mpk_pkg::PRICE_BITS-1:0] next_price(int shape,
         logic [mpk_pkg::PRICE_BITS-1:0] prev);
      int v;
      case (shape)
         0: v = $urandom_range(0, 65535);
         1: v = int'(prev) + $urandom_range(0, 600) - 300;
         2: v = $urandom_range(0, 1) ? 65535 - $urandom_range(0, 3) : $urandom_range(0, 3);
         default: v = int'(prev) + $urandom_range(0, 400) - 150;
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return mpk_pkg::PRICE_BITS'(v);
   endfunction

   initial begin
      int  len, shape, limit_roll;
      bit  quiet, pressed;
      logic first;
      logic [mpk_pkg::PRICE_BITS-1:0] p;
      sb = new();
      pressed = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Series straight out of reset, without a first flag, at the reset limit
      send_price(16'h0000, 1'b0);
      send_price(16'hFFFF, 1'b0);
      send_price(16'h0000, 1'b0);
      send_price(16'hFFFF, 1'b0);
      send_price(16'h0001, 1'b0);
      // New series with a single price, then alternating bit patterns
      send_price(16'hFFFF, 1'b1);
      send_price(16'hAAAA, 1'b1);
      send_price(16'h5555, 1'b0);
      // Zero trade limit
      drain();
      write_limit(7'd0);
      send_price(16'd50, 1'b1);
      send_price(16'd10, 1'b0);
      send_price(16'd60, 1'b0);
      send_price(16'd5, 1'b0);
      // Limit above the slot count, then lowered while the series goes on
      drain();
      write_limit(7'd127);
      send_price(16'd100, 1'b1);
      send_price(16'd300, 1'b0);
      send_price(16'd200, 1'b0);
      send_price(16'd900, 1'b0);
      send_price(16'd0, 1'b0);
      drain();
      write_limit(7'd1);
      send_price(16'd800, 1'b0);
      send_price(16'd50, 1'b0);
      send_price(16'd65535, 1'b0);

      // Random series: mostly well formed, with stray series starts and limit changes
      while (sent < ITEM_TARGET) begin
         calm = (sent >= CALM_FROM);
         if (!calm && $urandom_range(0, 3) == 0) begin
            drain();
            write_limit(pick_limit());
         end
         quiet = calm || ($urandom_range(0, 3) == 0);
         limit_roll = $urandom_range(0, 19);
         if (limit_roll == 0) len = 1;
         else if (limit_roll <= 2) len = $urandom_range(130, 200);
         else len = $urandom_range(2, 40);
         shape = $urandom_range(0, 3);
         p = mpk_pkg::PRICE_BITS'($urandom_range(0, 65535));
         // Hold the result side off while prices keep coming back to back
         if (!pressed && sent >= PRESSURE_AT) begin
            pressed = 1'b1;
            hold_off_req = 1'b1;
            quiet = 1'b1;
            len = 40;
         end
         for (int i = 0; i < len; i++) begin
            if (i == 0) first = ($urandom_range(0, 5) != 0);
            else first = ($urandom_range(0, 39) == 0);
            send_price(p, first);
            if (!quiet && $urandom_range(0, 4) == 0) pause($urandom_range(1, 7));
            p = next_price(shape, p);
         end
      end

      drain();
      if (sb.pending() != 0) sb.report($sformatf("%0d profits never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
